// ===== hdl/frwt_pkg.sv =====
// Package for the fractional rank block: sizes, the cell record and the
// sequencer states. No dependencies; every other file imports it.
`default_nettype none

package frwt_pkg;

    localparam int MAX_KEYS  = 64;
    localparam int KEY_WIDTH = 32;
    localparam int FIELD_W   = 32;
    localparam int EFF_W     = (KEY_WIDTH < FIELD_W) ? KEY_WIDTH : FIELD_W;
    localparam int CNT_W     = $clog2(MAX_KEYS + 1);
    localparam int STEP_W    = $clog2(MAX_KEYS);
    localparam int POS_W     = 6;
    localparam int RANK_W    = 8;
    localparam int OUT_W     = 16;

    typedef enum logic [1:0] {
        S_LOAD,
        S_RANK,
        S_EMIT
    } t_state;

    // One stored key and its running doubled rank.
    typedef struct packed {
        logic signed [EFF_W-1:0] key;
        logic [RANK_W-1:0]       rank;
    } t_cell;

    typedef struct packed {
        logic shift;
        logic rank_en;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== hdl/frwt_cell.sv =====
// One cell of the key chain: holds a key and its doubled rank, compares
// against the broadcast key and hands its record to the lower neighbor.
// Depends on frwt_pkg.
`default_nettype none

module frwt_cell (
    input  wire logic                            i_clk,
    input  wire frwt_pkg::t_cell_ctl             i_ctl,
    input  wire logic                            i_wr,
    input  wire logic                            i_last,
    input  wire logic signed [frwt_pkg::EFF_W-1:0] i_key,
    input  wire logic signed [frwt_pkg::EFF_W-1:0] i_bcast,
    input  wire frwt_pkg::t_cell                 i_next,
    input  wire frwt_pkg::t_cell                 i_wrap,
    output frwt_pkg::t_cell                      o_cell,
    output frwt_pkg::t_cell                      o_upd
);
    import frwt_pkg::*;

    t_cell             r_cell;
    logic [RANK_W-1:0] w_inc;

    // A smaller broadcast key adds two half units, an equal one adds one.
    always_comb begin
        w_inc = '0;
        if (i_bcast < r_cell.key) begin
            w_inc = RANK_W'(2);
        end else if (i_bcast == r_cell.key) begin
            w_inc = RANK_W'(1);
        end
        o_upd.key  = r_cell.key;
        o_upd.rank = i_ctl.rank_en ? (r_cell.rank + w_inc) : r_cell.rank;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_cell.key  <= i_key;
            r_cell.rank <= RANK_W'(1);
        end else if (i_ctl.shift) begin
            r_cell <= i_last ? i_wrap : i_next;
        end
    end

    assign o_cell = r_cell;

endmodule

`default_nettype wire

// ===== hdl/frwt_ctrl.sv =====
// Sequencer for the fractional rank block: load, rank rotation and result
// phases, key count and drop flag. Depends on frwt_pkg.
`default_nettype none

module frwt_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_in_last,
    input  wire logic                          i_out_ready,
    output logic                               o_in_ready,
    output logic                               o_out_valid,
    output logic                               o_wr,
    output frwt_pkg::t_cell_ctl                o_ctl,
    output logic [frwt_pkg::CNT_W-1:0]         o_count,
    output logic [frwt_pkg::STEP_W-1:0]        o_step,
    output logic                               o_final,
    output logic                               o_dropped
);
    import frwt_pkg::*;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [STEP_W-1:0]  r_step, n_step;
    logic               r_ovf, n_ovf;
    logic [CNT_W-1:0]   w_cnt_m1;
    logic               w_last_step;
    logic               w_room;

    assign w_cnt_m1    = r_count - CNT_W'(1);
    assign w_last_step = (r_step == w_cnt_m1[STEP_W-1:0]);
    assign w_room      = (r_count < CNT_W'(MAX_KEYS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_step  <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_step  <= n_step;
            r_ovf   <= n_ovf;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_step        = r_step;
        n_ovf         = r_ovf;
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        o_wr          = 1'b0;
        o_ctl.shift   = 1'b0;
        o_ctl.rank_en = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (w_room) begin
                        o_wr    = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_last) begin
                        n_state = S_RANK;
                        n_step  = '0;
                    end
                end
            end
            S_RANK: begin
                // Each rotation broadcasts the key at the chain head to all cells.
                o_ctl.shift   = 1'b1;
                o_ctl.rank_en = 1'b1;
                n_step        = r_step + STEP_W'(1);
                if (w_last_step) begin
                    n_step  = '0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_ctl.shift = 1'b1;
                    n_step      = r_step + STEP_W'(1);
                    if (w_last_step) begin
                        n_step  = '0;
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = S_LOAD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    assign o_count   = r_count;
    assign o_step    = r_step;
    assign o_final   = w_last_step;
    assign o_dropped = r_ovf;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_KEYS))
        else $error("key count beyond capacity");

    a_rank_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RANK || r_state == S_EMIT) |-> (r_count != '0))
        else $error("ranking an empty set");

    a_sides_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output open together");

    a_set_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && w_last_step) |=> (r_count == '0 && !r_ovf))
        else $error("set state not cleared after last result");

endmodule

`default_nettype wire

// ===== hdl/fractional_rank_with_ties.sv =====
// Fractional ranking with averaged ties: keys stream in, the set's ranks stream out.
// Depends on frwt_pkg, frwt_cell and frwt_ctrl.
//
// Signed keys are taken one per cycle until the transaction with tlast set; up to
// MAX_KEYS keys are kept in a chain of cells and any further keys of the set are
// dropped and flagged on tuser of every result. The chain then rotates once per
// stored key, broadcasting the head key so every cell builds its doubled rank
// (1 + 2*smaller + equal), and the results leave in input order, one per cycle
// while the sink is ready, with tlast on the final one. The rank phase makes one
// broadcast compare per cycle. No input is taken between the final key of a set
// and the last result of that set.
`default_nettype none

module fractional_rank_with_ties (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_s_tvalid,
    output logic                              o_s_tready,
    input  wire logic [frwt_pkg::FIELD_W-1:0] i_s_tdata,  // [31:0] key_value
    input  wire logic                         i_s_tlast,  // set_end
    output logic                              o_m_tvalid,
    input  wire logic                         i_m_tready,
    output logic [frwt_pkg::OUT_W-1:0]        o_m_tdata,  // [5:0] position, [13:6] rank_doubled
    output logic                              o_m_tlast,  // final_rank
    output logic                              o_m_tuser   // keys_dropped
);
    import frwt_pkg::*;

    t_cell_ctl         w_ctl;
    logic              w_wr;
    logic [CNT_W-1:0]  w_count;
    logic [CNT_W-1:0]  w_cnt_m1;
    logic [STEP_W-1:0] w_step;
    logic              w_final;
    logic              w_dropped;
    logic signed [EFF_W-1:0] w_key;
    t_cell             w_cell [MAX_KEYS];
    t_cell             w_upd  [MAX_KEYS];

    assign w_key    = i_s_tdata[EFF_W-1:0];
    assign w_cnt_m1 = w_count - CNT_W'(1);

    frwt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .i_in_last   (i_s_tlast),
        .i_out_ready (i_m_tready),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .o_wr        (w_wr),
        .o_ctl       (w_ctl),
        .o_count     (w_count),
        .o_step      (w_step),
        .o_final     (w_final),
        .o_dropped   (w_dropped)
    );

    // Cell 0 is the chain head; the cell holding the newest key wraps to it.
    for (genvar g = 0; g < MAX_KEYS; g++) begin : g_cell
        frwt_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_wr    (w_wr && (w_count == CNT_W'(g))),
            .i_last  (w_cnt_m1 == CNT_W'(g)),
            .i_key   (w_key),
            .i_bcast (w_cell[0].key),
            .i_next  (w_upd[(g + 1) % MAX_KEYS]),
            .i_wrap  (w_upd[0]),
            .o_cell  (w_cell[g]),
            .o_upd   (w_upd[g])
        );
    end

    assign o_m_tdata = {{(OUT_W - POS_W - RANK_W){1'b0}}, w_cell[0].rank, POS_W'(w_step)};
    assign o_m_tlast = w_final;
    assign o_m_tuser = w_dropped;

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for fractional_rank_with_ties: streams key sets in and
// checks every doubled rank against a predictor kept in the bench.
// Depends on frwt_pkg and the fractional_rank_with_ties RTL.
`timescale 1ns / 100ps

module tb_top;

    import frwt_pkg::*;

    localparam int         STALL_LIMIT = 3000;           // cycles with no transaction at all
    localparam int         TAIL_CYCLES = 3 * MAX_KEYS + 20;
    localparam int         HOLD_CYCLES = 300;
    localparam int         RAND_ITEMS  = 250;
    localparam logic [7:0] NO_PIN      = 8'd0;           // a real doubled rank is never 0

    typedef struct packed {
        logic [FIELD_W-1:0] key;
        logic               last;
        logic [RANK_W-1:0]  pin;   // typed-in doubled rank, NO_PIN to use the predictor
    } key_row_t;

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [RANK_W-1:0] rank2;
        logic              last;
        logic              dropped;
    } rank_res_t;

    // Directed sets: a lone minimum, the extremes, an all-tie set, tied minimums,
    // and a mixed set with two tie groups.
    localparam key_row_t DIR_ROWS [16] = '{
        '{32'h8000_0000, 1'b1, 8'd2},
        '{32'h7FFF_FFFF, 1'b0, 8'd8},
        '{32'h8000_0000, 1'b0, 8'd2},
        '{32'h0000_0000, 1'b0, 8'd6},
        '{32'hFFFF_FFFF, 1'b1, 8'd4},
        '{32'h0000_0005, 1'b0, 8'd4},
        '{32'h0000_0005, 1'b0, 8'd4},
        '{32'h0000_0005, 1'b1, 8'd4},
        '{32'h8000_0000, 1'b0, 8'd3},
        '{32'h8000_0000, 1'b0, 8'd3},
        '{32'h7FFF_FFFF, 1'b1, 8'd6},
        '{32'h0000_0003, 1'b0, NO_PIN},
        '{32'hFFFF_FFF9, 1'b0, NO_PIN},
        '{32'h0000_0003, 1'b0, NO_PIN},
        '{32'h0000_000A, 1'b0, NO_PIN},
        '{32'hFFFF_FFF9, 1'b1, NO_PIN}
    };

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_s_tvalid = 1'b0;
    logic               o_s_tready;
    logic [FIELD_W-1:0] i_s_tdata  = '0;   // [31:0] key_value
    logic               i_s_tlast  = 1'b0; // set_end
    logic               o_m_tvalid;
    logic               i_m_tready = 1'b0;
    logic [OUT_W-1:0]   o_m_tdata;         // [5:0] position, [13:6] rank_doubled
    logic               o_m_tlast;         // final_rank
    logic               o_m_tuser;         // keys_dropped

    fractional_rank_with_ties dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Predictor state for the set being collected.
    logic signed [FIELD_W-1:0] set_keys [$];
    logic [RANK_W-1:0]         set_pins [$];
    bit                        set_overflow = 1'b0;
    rank_res_t                 rank_q [$];

    int errors        = 0;
    int results_seen  = 0;
    int keys_sent     = 0;
    int rand_sent     = 0;
    int sets_done     = 0;
    int overflow_sets = 0;
    bit in_random     = 1'b0;

    // Stores or drops one key; a set-ending key queues the ranks of the whole set.
    function automatic void take_key(logic [FIELD_W-1:0] key, logic last,
                                     logic [RANK_W-1:0] pin);
        int        less;
        int        equal;
        rank_res_t res;
        if (set_keys.size() < MAX_KEYS) begin
            set_keys.push_back($signed(key));
            set_pins.push_back(pin);
        end else begin
            set_overflow = 1'b1;
        end
        if (!last)
            return;
        for (int n = 0; n < set_keys.size(); n++) begin
            less  = 0;
            equal = 0;
            foreach (set_keys[i]) begin
                if (set_keys[i] == set_keys[n])
                    equal++;
                else if (set_keys[i] < set_keys[n])
                    less++;
            end
            res.position = n[POS_W-1:0];
            res.rank2    = (set_pins[n] != NO_PIN) ? set_pins[n] : RANK_W'(1 + 2 * less + equal);
            res.last     = (n == set_keys.size() - 1);
            res.dropped  = set_overflow;
            rank_q.push_back(res);
        end
        sets_done++;
        if (set_overflow)
            overflow_sets++;
        set_keys.delete();
        set_pins.delete();
        set_overflow = 1'b0;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Mixes full-range keys with a narrow band (many ties) and values at the extremes.
    function automatic logic [FIELD_W-1:0] pick_key();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return $urandom_range(0, 8) - 4;
            2:       return $urandom_range(0, 3) + 32'h8000_0000;
            default: return 32'h7FFF_FFFF - $urandom_range(0, 3);
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic push_key(input logic [FIELD_W-1:0] key, input logic last,
                            input logic [RANK_W-1:0] pin);
        bit calm;
        bit gap;
        calm = in_random && rand_sent >= 140 && rand_sent < 200;
        gap  = !calm && ($urandom_range(0, 99) < 25);
        while (gap) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
            gap = ($urandom_range(0, 99) < 25);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= key;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        take_key(key, last, pin);
        keys_sent++;
        if (in_random)
            rand_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_set(input int size);
        for (int i = 0; i < size; i++)
            push_key(pick_key(), i == size - 1, NO_PIN);
    endtask

    initial begin : stimulus
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (DIR_ROWS[r])
            push_key(DIR_ROWS[r].key, DIR_ROWS[r].last, DIR_ROWS[r].pin);
        in_random = 1'b1;
        // A full store whose maximum reaches the top doubled rank.
        for (int i = 0; i < MAX_KEYS; i++)
            push_key((i == 37) ? 32'h7FFF_FFFF : $urandom(), i == MAX_KEYS - 1, NO_PIN);
        // Two keys beyond capacity, the set end among the dropped ones.
        send_set(MAX_KEYS + 2);
        while (rand_sent < RAND_ITEMS)
            send_set(($urandom_range(0, 15) == 0) ? $urandom_range(9, MAX_KEYS)
                                                  : $urandom_range(1, 8));
        i_s_tvalid <= 1'b0;
        while (rank_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Ranked %0d sets from %0d keys (%0d sets lost keys to a full store),",
                 sets_done, keys_sent, overflow_sets);
        $display("%0d results checked, including ties, extremes and a long sink hold-off.",
                 results_seen);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Sink side: random backpressure, one calm stretch and one long hold-off.
    initial begin : sink
        int  hold;
        bit  held;
        hold = 0;
        held = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && results_seen >= 20) begin
                held = 1'b1;
                hold = HOLD_CYCLES;
            end
            if (hold > 0) begin
                hold--;
                i_m_tready <= 1'b0;
            end else if (results_seen >= 150 && results_seen < 220) begin
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= ($urandom_range(0, 99) >= 25);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        rank_res_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (rank_q.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected result, expected none, actual tdata %h tlast %b tuser %b",
                         $time, o_m_tdata, o_m_tlast, o_m_tuser);
            end else begin
                want = rank_q.pop_front();
                check_field("position", want.position, o_m_tdata[POS_W-1:0]);
                check_field("rank_doubled", want.rank2, o_m_tdata[POS_W +: RANK_W]);
                check_field("final_rank", want.last, o_m_tlast);
                check_field("keys_dropped", want.dropped, o_m_tuser);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t ns: no transaction for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, rank_q.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
